### hdl/fixed_point_cube_root_macros.svh
// Assertion macros for the fixed-point cube root block.
// Included by the modules that carry assertions; no other dependencies.
`ifndef FIXED_POINT_CUBE_ROOT_MACROS_SVH
`define FIXED_POINT_CUBE_ROOT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPCR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("fpcr check failed");
`define FPCR_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("fpcr check failed");
`else
`define FPCR_ASSERT(lbl, clk, rstn, prop)
`define FPCR_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### hdl/fpcr_pkg.sv
// Shared types, constants and the root table for the Q24 cube root.
// No dependencies.
package fpcr_pkg;

    localparam int QBITS = 31;
    localparam logic [31:0] Q24_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [31:0] est;
    } side_t;

    function automatic logic [26:0] root_tab(input logic [4:0] idx);
        logic [26:0] r;
        unique case (idx)
            5'd0:  r = 27'd0;
            5'd1:  r = 27'd42275899;
            5'd2:  r = 27'd53264305;
            5'd3:  r = 27'd60972429;
            5'd4:  r = 27'd67108864;
            5'd5:  r = 27'd72290842;
            5'd6:  r = 27'd76820523;
            5'd7:  r = 27'd80870878;
            5'd8:  r = 27'd84551799;
            5'd9:  r = 27'd87937442;
            5'd10: r = 27'd91080821;
            5'd11: r = 27'd94020860;
            5'd12: r = 27'd96787759;
            5'd13: r = 27'd99404837;
            5'd14: r = 27'd101891052;
            5'd15: r = 27'd104261505;
            5'd16: r = 27'd106528610;
            default: r = 27'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/fixed_point_cube_root.sv
// Throughput: one beat per cycle unless m_ready stalls; two 32-stage bit-per-stage dividers set the depth.
// A stall on m_ready freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; no clearing pass.
// Top level: normalize, table interpolation, Newton step via fpcr_div.
// Depends on fpcr_pkg, fpcr_div and the assertion macros.
`include "fixed_point_cube_root_macros.svh"
module fixed_point_cube_root
    import fpcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_root
);

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 1: magnitude and normalization
    logic        neg_in;
    logic [31:0] mag_in;
    logic [31:0] n0, n1, n2, n3;
    logic [3:0]  grp_in;
    assign neg_in = s_value[31];
    assign mag_in = !neg_in ? s_value :
                    (s_value == 32'h8000_0000) ? Q24_MAX : (32'd0 - s_value);

    always_comb begin
        n0 = mag_in;
        grp_in = '0;
        n1 = ((n0 & 32'hFFFF_FF00) == 32'd0) ? {n0[7:0], 24'b0} : n0;
        grp_in[3] = ((n0 & 32'hFFFF_FF00) == 32'd0);
        n2 = ((n1 & 32'hFFF0_0000) == 32'd0) ? {n1[19:0], 12'b0} : n1;
        grp_in[2] = ((n1 & 32'hFFF0_0000) == 32'd0);
        n3 = ((n2 & 32'hFC00_0000) == 32'd0) ? {n2[25:0], 6'b0} : n2;
        grp_in[1] = ((n2 & 32'hFC00_0000) == 32'd0);
        grp_in[0] = ((n3 & 32'hE000_0000) == 32'd0);
    end

    logic        v1_reg, neg1_reg, zero1_reg;
    logic [31:0] mag1_reg, norm1_reg;
    logic [3:0]  grp1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg1_reg  <= neg_in;
            zero1_reg <= (mag_in == 32'd0);
            mag1_reg  <= mag_in;
            norm1_reg <= grp_in[0] ? {n3[28:0], 3'b0} : n3;
            grp1_reg  <= grp_in;
        end
    end

    // stage 2: table lookup and interpolation product
    logic [4:0]  idx;
    logic [26:0] lo, hi, dlt;
    logic [23:0] alpha;
    assign idx   = {1'b0, norm1_reg[31:28]};
    assign alpha = norm1_reg[27:4];
    assign lo    = root_tab(idx);
    assign hi    = root_tab(idx + 5'd1);
    assign dlt   = hi - lo;

    logic        v2_reg, neg2_reg, zero2_reg;
    logic [31:0] mag2_reg;
    logic [3:0]  grp2_reg;
    logic [26:0] lo2_reg;
    logic [50:0] prod2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg2_reg  <= neg1_reg;
            zero2_reg <= zero1_reg;
            mag2_reg  <= mag1_reg;
            grp2_reg  <= grp1_reg;
            lo2_reg   <= lo;
            prod2_reg <= {24'b0, dlt} * {27'b0, alpha};
        end
    end

    // stage 3: estimate
    logic [26:0] est_raw;
    assign est_raw = lo2_reg + prod2_reg[50:24];

    logic        v3_reg;
    logic [31:0] mag3_reg;
    side_t       side3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag3_reg       <= mag2_reg;
            side3_reg.neg  <= neg2_reg;
            side3_reg.zero <= zero2_reg;
            side3_reg.est  <= {5'b0, est_raw >> grp2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Newton step divisions
    logic        d1_valid, d2_valid;
    logic [31:0] q1, q2;
    side_t       d1_side, d2_side;

    fpcr_div u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (v3_reg),
        .in_a     (mag3_reg),
        .in_b     (side3_reg.est),
        .in_side  (side3_reg),
        .out_valid(d1_valid),
        .out_q    (q1),
        .out_side (d1_side)
    );

    fpcr_div u_div2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (d1_valid),
        .in_a     (q1),
        .in_b     (d1_side.est),
        .in_side  (d1_side),
        .out_valid(d2_valid),
        .out_q    (q2),
        .out_side (d2_side)
    );

    // stage 4: 2x + q; stage 5: divide by three; output register
    logic        v4_reg, v5_reg, m_valid_reg;
    logic        neg4_reg, zero4_reg, neg5_reg, zero5_reg;
    logic [32:0] sum4_reg;
    logic [64:0] prod5_reg;
    logic [31:0] res5;
    logic [31:0] m_root_reg;

    assign res5 = prod5_reg[64:33];

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg4_reg   <= d2_side.neg;
            zero4_reg  <= d2_side.zero;
            sum4_reg   <= {d2_side.est, 1'b0} + {1'b0, q2};
            neg5_reg   <= neg4_reg;
            zero5_reg  <= zero4_reg;
            prod5_reg  <= {32'b0, sum4_reg} * {33'b0, THIRD_RECIP};
            m_root_reg <= zero5_reg ? 32'd0 : (neg5_reg ? (32'd0 - res5) : res5);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v4_reg      <= d2_valid;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_root  = m_root_reg;

    `FPCR_ASSERT(a_est_nonzero, aclk, aresetn, (v3_reg && !side3_reg.zero) |-> (side3_reg.est != 32'd0))
    `FPCR_ASSERT(a_est_range, aclk, aresetn, v3_reg |-> (side3_reg.est[31:27] == 5'd0))
    `FPCR_ASSERT(a_sum_fits, aclk, aresetn, v4_reg |-> (sum4_reg[32] == 1'b0))

endmodule

### hdl/fpcr_div.sv
// Pipelined saturating Q24 divider: q = min((a << 24) / b, 0x7FFFFFFF).
// One quotient bit per stage; uses fpcr_pkg and the assertion macros.
`include "fixed_point_cube_root_macros.svh"
module fpcr_div
    import fpcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] in_a,
    input  logic [31:0] in_b,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] out_q,
    output side_t       out_side
);

    logic [QBITS:0] v_reg;
    logic [QBITS:0] ovf_reg;
    logic [31:0]    rem_reg  [0:QBITS];
    logic [30:0]    low_reg  [0:QBITS];
    logic [30:0]    q_reg    [0:QBITS];
    logic [31:0]    b_reg    [0:QBITS];
    side_t          side_reg [0:QBITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[QBITS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= {7'b0, in_a[31:7]};
            low_reg[0]  <= {in_a[6:0], 24'b0};
            q_reg[0]    <= '0;
            ovf_reg[0]  <= {7'b0, in_a[31:7]} >= in_b;
            b_reg[0]    <= in_b;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < QBITS; i++) begin : g_step
        logic [32:0] t_next;
        logic [32:0] diff_next;
        logic        ge_next;
        assign t_next    = {rem_reg[i], low_reg[i][30]};
        assign diff_next = t_next - {1'b0, b_reg[i]};
        assign ge_next   = t_next >= {1'b0, b_reg[i]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1]  <= ge_next ? diff_next[31:0] : t_next[31:0];
                low_reg[i+1]  <= {low_reg[i][29:0], 1'b0};
                q_reg[i+1]    <= {q_reg[i][29:0], ge_next};
                ovf_reg[i+1]  <= ovf_reg[i];
                b_reg[i+1]    <= b_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[QBITS];
    assign out_q     = ovf_reg[QBITS] ? Q24_MAX : {1'b0, q_reg[QBITS]};
    assign out_side  = side_reg[QBITS];

    `FPCR_ASSERT(a_zero_div_sat, aclk, aresetn, (v_reg[0] && b_reg[0] == 32'd0) |-> ovf_reg[0])
    `FPCR_ASSERT(a_rem_below_div, aclk, aresetn, (v_reg[QBITS] && !ovf_reg[QBITS]) |-> (rem_reg[QBITS] < b_reg[QBITS]))
    `FPCR_ASSERT(a_hold_on_stall, aclk, aresetn, !adv |=> $stable(v_reg))

endmodule

### bench/tb.sv
// Testbench for fixed_point_cube_root: directed table plus random Q24 operands,
// each result checked against its known root or a local cube root predictor. Depends on fpcr_pkg and the block.
module tb;
    import fpcr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_root;

    fixed_point_cube_root i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_root(m_root)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    localparam logic [31:0] SAT = 32'h7FFF_FFFF;
    logic [31:0] root_q[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    int neg_cnt = 0;
    bit hold_long = 0;
    bit sender_done = 0;

    function automatic logic [31:0] cube_tab(input int i);
        logic [31:0] t [17] = '{32'd0, 32'd42275899, 32'd53264305, 32'd60972429,
            32'd67108864, 32'd72290842, 32'd76820523, 32'd80870878, 32'd84551799,
            32'd87937442, 32'd91080821, 32'd94020860, 32'd96787759, 32'd99404837,
            32'd101891052, 32'd104261505, 32'd106528610};
        return t[i];
    endfunction

    function automatic logic [31:0] qdiv(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] q;
        if (b == 0) return SAT;
        q = {a, 24'd0} / {32'd0, b};
        return (q > {32'd0, SAT}) ? SAT : q[31:0];
    endfunction

    function automatic logic [31:0] cube_root(input logic [31:0] raw);
        logic [31:0] mag, norm, lo, hi, est, q2, res;
        logic [63:0] prod, sum;
        int grp;
        grp = 0;
        if (raw[31]) mag = (raw == 32'h8000_0000) ? SAT : -raw;
        else mag = raw;
        if (mag == 0) return 32'd0;
        norm = mag;
        if ((norm & 32'hFFFF_FF00) == 0) begin norm = norm << 24; grp += 8; end
        if ((norm & 32'hFFF0_0000) == 0) begin norm = norm << 12; grp += 4; end
        if ((norm & 32'hFC00_0000) == 0) begin norm = norm << 6; grp += 2; end
        if ((norm & 32'hE000_0000) == 0) begin norm = norm << 3; grp += 1; end
        lo = cube_tab(norm[31:28]);
        hi = cube_tab(norm[31:28] + 1);
        prod = {32'd0, hi - lo} * {36'd0, norm[27:4]};
        est = (lo + prod[55:24]) >> grp;
        q2 = qdiv(qdiv(mag, est), est);
        sum = 2 * {32'd0, est} + {32'd0, q2};
        sum = sum / 3;
        res = sum[31:0];
        if (raw[31]) res = -res;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] a, input logic [31:0] b);
        errors++;
        $display("mismatch %s: got %h expected %h", what, a, b);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_value();
        int k;
        logic [31:0] v;
        k = $urandom_range(0, 5);
        v = $urandom;
        case (k)
            0: v = v >> $urandom_range(0, 31);
            1: v = -(v >> $urandom_range(0, 31));
            2: v = 32'd1 << $urandom_range(0, 31);
            3: v = $urandom_range(0, 3) + 32'h7FFF_FFFC;
            default: ;
        endcase
        return v;
    endfunction

    // directed rows: value, expected, has_expected
    typedef struct {
        logic [31:0] value;
        logic [31:0] root;
        bit          known;
    } row_t;
    row_t rows [] = '{
        '{32'h0000_0000, 32'd0, 1}, '{32'h0100_0000, 32'd0, 0},
        '{32'hFF00_0000, 32'd0, 0}, '{32'h0000_0001, 32'd0, 0},
        '{32'hFFFF_FFFF, 32'd0, 0}, '{32'h7FFF_FFFF, 32'd0, 0},
        '{32'h8000_0000, 32'd0, 0}, '{32'h8000_0001, 32'd0, 0},
        '{32'h0800_0000, 32'd0, 0}, '{32'h1B00_0000, 32'd0, 0},
        '{32'h0000_00FF, 32'd0, 0}, '{32'h0000_0100, 32'd0, 0},
        '{32'h000F_FFFF, 32'd0, 0}, '{32'h0010_0000, 32'd0, 0},
        '{32'h03FF_FFFF, 32'd0, 0}, '{32'h1FFF_FFFF, 32'd0, 0},
        '{32'h2000_0000, 32'd0, 0}, '{32'h5555_5555, 32'd0, 0},
        '{32'hAAAA_AAAA, 32'd0, 0}, '{32'h0000_0008, 32'd0, 0}
    };

    task automatic send(input logic [31:0] v, input logic [31:0] exp_root, input bit known);
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        root_q.push_back(known ? exp_root : cube_root(v));
        if (v[31]) neg_cnt++;
        sent++;
        @(negedge aclk);
    endtask

    task automatic gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (rows[i]) begin
            send(rows[i].value, rows[i].root, rows[i].known);
            gap();
        end
        for (int n = 0; n < 1130; n++) begin
            if (n == 300) hold_long = 1;
            if (n == 700) begin
                s_valid <= 1'b0;
                while (root_q.size() != 0) @(negedge aclk);
            end
            send(rand_value(), 32'd0, 0);
            if (n < 300 || n > 500) gap();
        end
        s_valid <= 1'b0;
        sender_done = 1;
    end

    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                hold_long = 0;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                m_ready <= 1'b1;
                repeat (20) @(negedge aclk);
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got++;
            if (root_q.size() == 0) report_mismatch("unexpected beat", m_root, 32'd0);
            else begin
                if (m_root !== root_q[0]) report_mismatch("root", m_root, root_q[0]);
                void'(root_q.pop_front());
            end
        end
    end

    initial begin
        wait (sender_done);
        while (root_q.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        $display("covered %0d operands (%0d negative), %0d result beats checked",
                 sent, neg_cnt, got);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end
endmodule
